>>> sv/mgpd_pkg.sv
// Shared types and constants for the magnetic guide position decoder.
package mgpd_pkg;

   localparam logic       CMD_FRAME        = 1'b0;
   localparam logic       CMD_TIMEOUT      = 1'b1;

   localparam logic [10:0] ID_FRONT        = 11'h042;
   localparam logic [10:0] ID_REAR         = 11'h043;
   localparam logic [3:0]  FRAME_LEN_SENSOR = 4'd3;

   localparam logic signed [1:0] DIR_FWD   = 2'sb01;
   localparam logic signed [1:0] DIR_REV   = 2'sb11;

   localparam logic [7:0]  MASK_FWD        = 8'hf8;
   localparam logic [7:0]  MASK_REV        = 8'h18;

   localparam logic [7:0]  LINK_LOST       = 8'd240;
   localparam logic signed [7:0] EMPTY_POS = 8'sd80;
   localparam logic signed [7:0] POS_MAX   = 8'sd127;
   localparam logic signed [7:0] POS_MIN   = -8'sd128;
   localparam logic [4:0]  COUNT_MAX       = 5'd31;

   // Per-item job handed from the front end to the back end.
   typedef struct packed {
      logic       recompute;
      logic [7:0] link_front;
      logic [7:0] link_rear;
   } mgpd_job_type;

   // One result item, fields from the lowest bit up in reverse order here.
   typedef struct packed {
      logic              recomputed;
      logic [7:0]        link_rear;
      logic [7:0]        link_front;
      logic [4:0]        count_rear;
      logic [4:0]        count_front;
      logic signed [7:0] position_rear;
      logic signed [7:0] position_front;
   } mgpd_result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DIV_START,
      BK_DIV_WAIT,
      BK_OUT
   } mgpd_back_state_type;

endpackage

>>> sv/mgpd_front.sv
// Front end: accepts items, steps link counters and updates stored patterns.
module mgpd_front
   import mgpd_pkg::*;
#(
   parameter int SENSOR_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [10:0]                  req_frame_id,
   input  logic [3:0]                   req_frame_len,
   input  logic [23:0]                  req_payload,
   input  logic signed [1:0]            req_travel_dir,
   output logic                         push_valid,
   input  logic                         push_ready,
   output mgpd_job_type                 push_job,
   output logic [1:0][SENSOR_BITS-1:0]  push_pattern
);

   logic [1:0][7:0]             link_ff, link_in;
   logic [1:0][SENSOR_BITS-1:0] pat_ff, pat_in;
   logic [SENSOR_BITS:0]        payload_x;
   logic [SENSOR_BITS-1:0]      dir_mask;
   logic                        valid_frame;
   logic                        sel_rear;
   logic                        accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign payload_x  = (SENSOR_BITS + 1)'(req_payload);
   assign sel_rear   = (req_frame_id == ID_REAR);

   assign valid_frame = (req_cmd == CMD_FRAME) && (req_frame_len == FRAME_LEN_SENSOR) &&
                        ((req_frame_id == ID_FRONT) || (req_frame_id == ID_REAR));

   always_comb begin
      link_in  = link_ff;
      pat_in   = pat_ff;
      dir_mask = '1;
      if (req_travel_dir == DIR_FWD) begin
         dir_mask = SENSOR_BITS'(MASK_FWD);
      end else if (req_travel_dir == DIR_REV) begin
         dir_mask = SENSOR_BITS'(MASK_REV);
      end
      if (req_cmd == CMD_TIMEOUT) begin
         link_in[0] = LINK_LOST;
         link_in[1] = LINK_LOST;
      end else begin
         for (int s = 0; s < 2; s++) begin
            link_in[s] = (link_ff[s] > LINK_LOST) ? LINK_LOST : link_ff[s] + 8'd1;
         end
         if (valid_frame) begin
            link_in[sel_rear] = '0;
            pat_in[sel_rear]  = payload_x[SENSOR_BITS:1];
            pat_in[0]         = pat_in[0] & dir_mask;
            pat_in[1]         = pat_in[1] & dir_mask;
         end
      end
   end

   assign push_job.recompute  = valid_frame;
   assign push_job.link_front = link_in[0];
   assign push_job.link_rear  = link_in[1];
   assign push_pattern        = pat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
         pat_ff  <= '0;
      end else if (accept) begin
         link_ff <= link_in;
         pat_ff  <= pat_in;
      end
   end

endmodule

>>> sv/mgpd_queue.sv
// Small first-in first-out queue between the front and back ends.
module mgpd_queue #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

>>> sv/mgpd_divider.sv
// Restoring unsigned divider producing one quotient bit per cycle.
module mgpd_divider #(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR_W  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int KW = $clog2(DIVIDEND_W);

   logic                  busy_ff, done_ff;
   logic [KW-1:0]         cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff, den_ff;
   logic [DIVISOR_W:0]    trial, diff;
   logic                  fits;

   assign trial    = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign fits     = (trial >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + KW'(1);
            if (cnt_ff == KW'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

endmodule

>>> sv/mgpd_back.sv
// Back end: centroid scan, shared division and the result register.
module mgpd_back
   import mgpd_pkg::*;
#(
   parameter int SENSOR_BITS     = 16,
   parameter int ELEMENT_SPACING = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  mgpd_job_type                 job,
   input  logic [1:0][SENSOR_BITS-1:0]  pattern,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mgpd_result_type              rsp_result
);

   localparam int MAG_W = $clog2(SENSOR_BITS * (SENSOR_BITS - 1) * ELEMENT_SPACING + 1);
   localparam int SUM_W = MAG_W + 1;
   localparam int IW    = $clog2(SENSOR_BITS);
   localparam int NW    = $clog2(SENSOR_BITS + 1);
   localparam int QX    = (MAG_W > 9) ? MAG_W : 9;
   localparam int NX    = (NW > 6) ? NW : 6;
   localparam logic signed [SUM_W-1:0] TERM0 =
      SUM_W'(-(SENSOR_BITS - 1) * ELEMENT_SPACING);
   localparam logic signed [SUM_W-1:0] TERM_STEP = SUM_W'(2 * ELEMENT_SPACING);

   mgpd_back_state_type state_ff, state_in;

   logic                         out_valid_ff;
   mgpd_result_type              out_ff;
   mgpd_job_type                 job_ff;
   logic [1:0][SENSOR_BITS-1:0]  pat_ff;
   logic [IW-1:0]                idx_ff;
   logic signed [SUM_W-1:0]      term_ff;
   logic signed [SUM_W-1:0]      sum_ff [2];
   logic [NW-1:0]                n_ff [2];
   logic                         sel_ff;
   logic signed [7:0]            pos_ff [2];
   logic [4:0]                   cnt_ff [2];

   logic                         out_free;
   logic                         pop, load_direct, start_scan, scan_step;
   logic                         div_start, div_store, load_out;
   logic                         div_done;
   logic [MAG_W-1:0]             div_quotient;
   logic signed [SUM_W-1:0]      sel_sum, sel_abs;
   logic [NW-1:0]                sel_n;
   logic [QX-1:0]                q_x;
   logic signed [7:0]            new_pos;
   logic [4:0]                   new_cnt;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign job_ready  = (state_ff == BK_IDLE) && out_free;
   assign pop        = job_valid && job_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   assign sel_sum = sum_ff[sel_ff];
   assign sel_n   = n_ff[sel_ff];
   assign sel_abs = (sel_sum < 0) ? -sel_sum : sel_sum;
   assign q_x     = QX'(div_quotient);

   mgpd_divider #(
      .DIVIDEND_W (MAG_W),
      .DIVISOR_W  (NW + 1)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sel_abs[MAG_W-1:0]),
      .divisor  ({sel_n, 1'b0}),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      if (sel_n == '0) begin
         new_pos = (pos_ff[sel_ff] > 0) ? EMPTY_POS : -EMPTY_POS;
      end else if (sel_sum < 0) begin
         new_pos = (q_x > QX'(128)) ? POS_MIN : -(8'(q_x));
      end else begin
         new_pos = (q_x > QX'(127)) ? POS_MAX : 8'(q_x);
      end
      new_cnt = (NX'(sel_n) > NX'(COUNT_MAX)) ? COUNT_MAX : 5'(sel_n);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop && job.recompute) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (idx_ff == IW'(SENSOR_BITS - 1)) begin
               state_in = BK_DIV_START;
            end
         end
         BK_DIV_START: begin
            state_in = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_done) begin
               state_in = sel_ff ? BK_OUT : BK_DIV_START;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control decode.
   always_comb begin
      load_direct = 1'b0;
      start_scan  = 1'b0;
      scan_step   = 1'b0;
      div_start   = 1'b0;
      div_store   = 1'b0;
      load_out    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            load_direct = pop && !job.recompute;
            start_scan  = pop && job.recompute;
         end
         BK_SCAN:      scan_step = 1'b1;
         BK_DIV_START: div_start = 1'b1;
         BK_DIV_WAIT:  div_store = div_done;
         BK_OUT:       load_out  = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         for (int s = 0; s < 2; s++) begin
            pos_ff[s] <= '0;
            cnt_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_direct || load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (start_scan) begin
            sel_ff <= 1'b0;
         end else if (div_store) begin
            sel_ff <= 1'b1;
         end
         if (div_store) begin
            pos_ff[sel_ff] <= new_pos;
            cnt_ff[sel_ff] <= new_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_scan) begin
         job_ff  <= job;
         pat_ff  <= pattern;
         idx_ff  <= '0;
         term_ff <= TERM0;
         for (int s = 0; s < 2; s++) begin
            sum_ff[s] <= '0;
            n_ff[s]   <= '0;
         end
      end else if (scan_step) begin
         idx_ff  <= idx_ff + IW'(1);
         term_ff <= term_ff + TERM_STEP;
         for (int s = 0; s < 2; s++) begin
            if (pat_ff[s][idx_ff]) begin
               sum_ff[s] <= sum_ff[s] + term_ff;
               n_ff[s]   <= n_ff[s] + NW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct) begin
         out_ff.recomputed     <= 1'b0;
         out_ff.link_front     <= job.link_front;
         out_ff.link_rear      <= job.link_rear;
         out_ff.count_front    <= cnt_ff[0];
         out_ff.count_rear     <= cnt_ff[1];
         out_ff.position_front <= pos_ff[0];
         out_ff.position_rear  <= pos_ff[1];
      end else if (load_out) begin
         out_ff.recomputed     <= 1'b1;
         out_ff.link_front     <= job_ff.link_front;
         out_ff.link_rear      <= job_ff.link_rear;
         out_ff.count_front    <= cnt_ff[0];
         out_ff.count_rear     <= cnt_ff[1];
         out_ff.position_front <= pos_ff[0];
         out_ff.position_rear  <= pos_ff[1];
      end
   end

endmodule

>>> sv/magnetic_guide_position_decoder.sv
// Top level of the magnetic guide position decoder: front end, job queue, back end.
// Items that do not update the sensors pass the queue to the result register and flow at
// one per cycle while rsp_tready stays high. A valid sensor frame is popped, scanned over
// SENSOR_BITS elements, divided twice in the shared one-bit-per-cycle divider and loaded
// into the result register; meanwhile the back end takes no other item but the queue does.
// Reset is synchronous and active high; it clears patterns, positions, counts and links.
module magnetic_guide_position_decoder
   import mgpd_pkg::*;
#(
   parameter int SENSOR_BITS     = 16,
   parameter int ELEMENT_SPACING = 10
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   // frame_id [10:0], frame_len [14:11], payload [38:15], travel_dir [40:39], zero above.
   input  logic [47:0] req_tdata,
   // cmd [0]: 0 for a received frame, 1 for a receive timeout tick.
   input  logic        req_tuser,
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // position_front [7:0], position_rear [15:8], count_front [20:16], count_rear [25:21],
   // link_front [33:26], link_rear [41:34], zero above.
   output logic [47:0] rsp_tdata,
   // recomputed [0].
   output logic        rsp_tuser
);

   localparam int QUEUE_W = $bits(mgpd_job_type) + 2 * SENSOR_BITS;

   // Handshake between the front end and the queue.
   logic                        push_valid, push_ready;
   mgpd_job_type                push_job;
   logic [1:0][SENSOR_BITS-1:0] push_pattern;

   // Handshake between the queue and the back end.
   logic                        pop_valid, pop_ready;
   logic [QUEUE_W-1:0]          pop_data;
   mgpd_job_type                pop_job;
   logic [1:0][SENSOR_BITS-1:0] pop_pattern;

   mgpd_result_type             result;

   // The front end updates link counters and stored patterns the moment an item is
   // accepted, so every later item sees the state its predecessors left behind.
   mgpd_front #(
      .SENSOR_BITS (SENSOR_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_cmd        (req_tuser),
      .req_frame_id   (req_tdata[10:0]),
      .req_frame_len  (req_tdata[14:11]),
      .req_payload    (req_tdata[38:15]),
      .req_travel_dir (req_tdata[40:39]),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job),
      .push_pattern   (push_pattern)
   );

   // The queue lets new items come in while the back end is busy with a centroid.
   mgpd_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (4)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_pattern, push_job}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_job     = pop_data[$bits(mgpd_job_type)-1:0];
   assign pop_pattern = pop_data[QUEUE_W-1:$bits(mgpd_job_type)];

   // The back end owns the stored positions and counts and the result register.
   mgpd_back #(
      .SENSOR_BITS     (SENSOR_BITS),
      .ELEMENT_SPACING (ELEMENT_SPACING)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .pattern    (pop_pattern),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {6'd0, result.link_rear, result.link_front, result.count_rear,
                       result.count_front, result.position_rear, result.position_front};
   assign rsp_tuser = result.recomputed;

endmodule
